[hdl/ps2_scancode_to_ascii_macros.svh]
// assertion macros for the ps2 scan code decoder
// used by the top level only, needs a signal named clock and one named reset
`ifndef PS2_SCANCODE_TO_ASCII_MACROS_SVH
`define PS2_SCANCODE_TO_ASCII_MACROS_SVH

// condition in the same cycle
`define PS2SC_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("ps2sc same-cycle check failed");

// condition in the next cycle
`define PS2SC_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("ps2sc next-cycle check failed");

`endif

[hdl/ps2sc_pkg.sv]
// shared types, key codes and character tables for the ps2 scan code decoder
// no dependencies
`default_nettype none

package ps2sc_pkg;

   // keyboard flags carried between the key map and the top level
   typedef struct packed {
      logic release_pending;
      logic shift_held;
      logic caps_on;
   } key_flags_type;

   // scan codes with special meaning (set 2)
   localparam logic [7:0] CODE_SHIFT_LEFT  = 8'h12;
   localparam logic [7:0] CODE_SHIFT_RIGHT = 8'h59;
   localparam logic [7:0] CODE_CAPS_LOCK   = 8'h58;
   localparam logic [7:0] CODE_RELEASE     = 8'hF0;

   // lowercase letter window and case offset
   localparam logic [6:0] LOWER_BELOW = 7'h60;
   localparam logic [6:0] LOWER_ABOVE = 7'h7B;
   localparam logic [6:0] CASE_OFFSET = 7'h20;

   localparam int unsigned CHAR_WIDTH = 7;
   localparam int unsigned ROM_DEPTH  = 128;

   typedef logic [CHAR_WIDTH-1:0] char_type;

   // character table without shift
   localparam char_type ROM_PLAIN [ROM_DEPTH] = '{
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd27, 7'd27, 7'd0,
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd9, 7'd96, 7'd0,
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd113, 7'd49, 7'd0,
      7'd0, 7'd0, 7'd122, 7'd115, 7'd97, 7'd119, 7'd50, 7'd0,
      7'd0, 7'd99, 7'd120, 7'd100, 7'd101, 7'd52, 7'd51, 7'd0,
      7'd0, 7'd32, 7'd118, 7'd102, 7'd116, 7'd114, 7'd53, 7'd0,
      7'd0, 7'd110, 7'd98, 7'd104, 7'd103, 7'd121, 7'd54, 7'd0,
      7'd0, 7'd0, 7'd109, 7'd106, 7'd117, 7'd55, 7'd56, 7'd0,
      7'd0, 7'd44, 7'd107, 7'd105, 7'd111, 7'd48, 7'd57, 7'd0,
      7'd0, 7'd46, 7'd47, 7'd108, 7'd59, 7'd112, 7'd45, 7'd0,
      7'd0, 7'd0, 7'd39, 7'd0, 7'd91, 7'd61, 7'd0, 7'd0,
      7'd0, 7'd0, 7'd10, 7'd93, 7'd0, 7'd124, 7'd0, 7'd0,
      7'd0, 7'd60, 7'd0, 7'd0, 7'd0, 7'd0, 7'd8, 7'd0,
      7'd0, 7'd49, 7'd0, 7'd52, 7'd55, 7'd0, 7'd0, 7'd0,
      7'd0, 7'd46, 7'd50, 7'd53, 7'd54, 7'd56, 7'd27, 7'd0,
      7'd0, 7'd43, 7'd51, 7'd45, 7'd42, 7'd57, 7'd0, 7'd0
   };

   // character table with shift held
   localparam char_type ROM_SHIFT [ROM_DEPTH] = '{
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd126, 7'd0,
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd81, 7'd33, 7'd0,
      7'd0, 7'd0, 7'd90, 7'd83, 7'd65, 7'd87, 7'd64, 7'd35,
      7'd0, 7'd67, 7'd88, 7'd68, 7'd69, 7'd36, 7'd35, 7'd0,
      7'd0, 7'd32, 7'd86, 7'd70, 7'd84, 7'd82, 7'd37, 7'd0,
      7'd0, 7'd78, 7'd66, 7'd72, 7'd71, 7'd89, 7'd94, 7'd0,
      7'd0, 7'd0, 7'd77, 7'd74, 7'd85, 7'd38, 7'd42, 7'd0,
      7'd0, 7'd60, 7'd75, 7'd73, 7'd79, 7'd41, 7'd40, 7'd0,
      7'd0, 7'd62, 7'd63, 7'd76, 7'd58, 7'd80, 7'd95, 7'd0,
      7'd0, 7'd0, 7'd34, 7'd0, 7'd123, 7'd43, 7'd0, 7'd0,
      7'd0, 7'd0, 7'd0, 7'd125, 7'd0, 7'd92, 7'd0, 7'd0,
      7'd0, 7'd62, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
   };

endpackage

`default_nettype wire

[hdl/ps2_scancode_to_ascii.sv]
// ps2 scan code set 2 to ascii decoder, top level
// depends on ps2sc_pkg, ps2sc_keymap and ps2_scancode_to_ascii_macros.svh
//
// usage:
//   req channel carries one keyboard byte per transaction (req_tdata[7:0]).
//   rsp channel carries one decoded character per key press (rsp_tdata[6:0]).
//   bytes that are a release prefix, a release, a shift or caps lock key,
//   or that map to no character produce no rsp transaction.
//   a byte accepted on req is registered in the input register, then its
//   character is registered in the result register, which drives rsp.
//   throughput: one byte per cycle while the result register is free or being
//   emptied, set by the single input register feeding the key map lookup and the result register.
//   stall: while a result waits with rsp_tready low the result register
//   holds; one more byte is taken into the input register, then req_tready
//   drops until the result is taken.
//   reset: synchronous, active high; clears both pipeline stages and the
//   release, shift and caps lock flags.
`default_nettype none

`include "ps2_scancode_to_ascii_macros.svh"

module ps2_scancode_to_ascii (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output      logic       req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] scan_code
   output      logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   output      logic [7:0] rsp_tdata    // [6:0] ascii_char, [7] zero
);

   logic                     s1_valid_ff, s1_valid_in;
   logic [7:0]               s1_code_ff, s1_code_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   ps2sc_pkg::char_type      rsp_char_ff, rsp_char_in;
   logic                     advance;
   logic                     char_valid;
   ps2sc_pkg::char_type      char_out;
   ps2sc_pkg::key_flags_type flags;
   logic                     prefix_step;
   logic                     after_prefix_step;

   // input stage moves on when the result register is free or being emptied
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   ps2sc_keymap u_keymap (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .code       (s1_code_ff),
      .char_valid (char_valid),
      .char_out   (char_out),
      .flags      (flags)
   );

   // input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_code_in  = s1_code_ff;
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
         s1_code_in  = req_tdata;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      if (advance) begin
         rsp_valid_in = char_valid;
         rsp_char_in  = char_out;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_code_ff  <= s1_code_in;
      rsp_char_ff <= rsp_char_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};

   // release prefix consumed, and a byte consumed right after one
   assign prefix_step       = advance && (s1_code_ff == ps2sc_pkg::CODE_RELEASE);
   assign after_prefix_step = advance && flags.release_pending
                              && (s1_code_ff != ps2sc_pkg::CODE_RELEASE);

   // a shown character is never zero
   `PS2SC_ASSERT_SAME(a_char_nonzero, rsp_valid_ff, rsp_char_ff != '0)
   // a release prefix arms the release flag
   `PS2SC_ASSERT_NEXT(a_release_arms, prefix_step, flags.release_pending)
   // the byte after a release prefix never yields a character
   `PS2SC_ASSERT_NEXT(a_release_silent, after_prefix_step, !rsp_valid_ff)

endmodule

`default_nettype wire

[hdl/ps2sc_keymap.sv]
// key map: flag registers and character lookup for one scan code byte
// depends on ps2sc_pkg
`default_nettype none

module ps2sc_keymap (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,       // byte is consumed this cycle
   input  wire logic [7:0]             code,
   output      logic                   char_valid,
   output      ps2sc_pkg::char_type    char_out,
   output      ps2sc_pkg::key_flags_type flags
);

   ps2sc_pkg::key_flags_type flags_ff, flags_in;
   ps2sc_pkg::char_type      rom_char;
   logic                     is_release;
   logic                     is_shift;
   logic                     is_caps;
   logic                     is_lower;

   // byte classification
   always_comb begin
      is_release = (code == ps2sc_pkg::CODE_RELEASE);
      is_shift   = code inside {ps2sc_pkg::CODE_SHIFT_LEFT, ps2sc_pkg::CODE_SHIFT_RIGHT};
      is_caps    = (code == ps2sc_pkg::CODE_CAPS_LOCK);
   end

   // table lookup with caps lock fold
   always_comb begin
      if (flags_ff.shift_held) begin
         rom_char = ps2sc_pkg::ROM_SHIFT[code[6:0]];
      end else begin
         rom_char = ps2sc_pkg::ROM_PLAIN[code[6:0]];
      end
      is_lower = (rom_char > ps2sc_pkg::LOWER_BELOW) && (rom_char < ps2sc_pkg::LOWER_ABOVE);
      if (flags_ff.caps_on && is_lower) begin
         char_out = rom_char - ps2sc_pkg::CASE_OFFSET;
      end else begin
         char_out = rom_char;
      end
      char_valid = !flags_ff.release_pending && !is_release && !is_shift && !is_caps
                   && (rom_char != '0);
   end

   // flag updates
   always_comb begin
      flags_in = flags_ff;
      if (step) begin
         if (is_release) begin
            flags_in.release_pending = 1'b1;
         end else begin
            if (is_shift) begin
               flags_in.shift_held = !flags_ff.release_pending;
            end else if (is_caps && !flags_ff.release_pending) begin
               flags_in.caps_on = !flags_ff.caps_on;
            end
            flags_in.release_pending = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   assign flags = flags_ff;

endmodule

`default_nettype wire

[tb/sv/ps2sc_char_checker.sv]
// checker for the ps2 scan code decoder: watches both stream channels,
// predicts each decoded character and compares it with the block's output
// depends on ps2sc_pkg (flag struct, key codes, character tables)

module ps2sc_char_checker
   import ps2sc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire logic       req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] scan_code
   input  wire logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire logic [7:0] rsp_tdata,   // [6:0] ascii_char, [7] zero
   output int              mismatch_count,
   output int              chars_pending,
   output int              chars_checked
);

   localparam int REPORT_LIMIT = 10;

   key_flags_type kbd_flags;
   char_type      expected_chars [$];
   char_type      want_char;
   int            mismatches = 0;
   int            checked = 0;

   // one keyboard byte through the flag logic and the character tables
   task automatic decode_byte(input logic [7:0] code);
      char_type ch;
      if (code == CODE_RELEASE) begin
         kbd_flags.release_pending = 1'b1;
      end else begin
         if (code == CODE_SHIFT_LEFT || code == CODE_SHIFT_RIGHT) begin
            kbd_flags.shift_held = !kbd_flags.release_pending;
         end else if (code == CODE_CAPS_LOCK) begin
            if (!kbd_flags.release_pending)
               kbd_flags.caps_on = !kbd_flags.caps_on;
         end else if (!kbd_flags.release_pending) begin
            // only the low seven bits select the table entry
            ch = kbd_flags.shift_held ? ROM_SHIFT[code[6:0]] : ROM_PLAIN[code[6:0]];
            if (kbd_flags.caps_on && ch > LOWER_BELOW && ch < LOWER_ABOVE)
               ch = ch - CASE_OFFSET;
            if (ch != '0)
               expected_chars.push_back(ch);
         end
         kbd_flags.release_pending = 1'b0;
      end
   endtask

   // compare output transactions first, then predict from the input transaction
   always @(posedge clock) begin
      if (reset) begin
         kbd_flags = '0;
         expected_chars.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("checker: unexpected character %02h", rsp_tdata);
            end else begin
               want_char = expected_chars.pop_front();
               checked++;
               if (rsp_tdata !== {1'b0, want_char}) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("checker: character mismatch, expected %02h got %02h",
                              {1'b0, want_char}, rsp_tdata);
               end
            end
         end
         if (req_tvalid && req_tready)
            decode_byte(req_tdata);
      end
      mismatch_count <= mismatches;
      chars_pending  <= expected_chars.size();
      chars_checked  <= checked;
   end

endmodule

[tb/sv/tb.sv]
// testbench top for the ps2 scan code decoder: clock, reset, keyboard byte
// stimulus, output back-pressure and the final verdict
// depends on ps2sc_pkg, ps2_scancode_to_ascii and ps2sc_char_checker

module tb;
   import ps2sc_pkg::*;

   localparam int ITEM_TARGET  = 1650;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_PERCENT = 25;
   localparam int DRAIN_CYCLES = 4;

   // ordinary keys used by the directed part
   localparam logic [7:0] KEY_A         = 8'h1C;
   localparam logic [7:0] KEY_B         = 8'h32;
   localparam logic [7:0] KEY_1         = 8'h16;
   localparam logic [7:0] KEY_BACKTICK  = 8'h0E;
   localparam logic [7:0] KEY_PIPE      = 8'h5D;
   localparam logic [7:0] CODE_EXTENDED = 8'hE0;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic [7:0] req_tdata = 8'h00;
   logic       rsp_tready = 1'b0;
   wire logic       req_tready;
   wire logic       rsp_tvalid;
   wire logic [7:0] rsp_tdata;

   int mismatch_count;
   int chars_pending;
   int chars_checked;
   int codes_sent = 0;
   int cycle_count = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   bit calm = 1'b0;

   // extremes, release prefixes, shift, caps lock with and without shift,
   // release of caps lock, extended prefix, table entries of zero
   logic [7:0] directed_codes [25] = '{
      8'h00, 8'hFF, 8'h7F, 8'h80,
      CODE_RELEASE, CODE_RELEASE, KEY_A,
      KEY_A,
      CODE_SHIFT_LEFT, KEY_A, CODE_RELEASE, CODE_SHIFT_LEFT,
      CODE_CAPS_LOCK, KEY_A,
      CODE_SHIFT_RIGHT, KEY_A, KEY_1, CODE_RELEASE, CODE_SHIFT_RIGHT,
      CODE_RELEASE, CODE_CAPS_LOCK,
      KEY_BACKTICK,
      CODE_CAPS_LOCK,
      CODE_EXTENDED,
      KEY_PIPE
   };

   ps2_scancode_to_ascii u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ps2sc_char_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .chars_pending  (chars_pending),
      .chars_checked  (chars_checked)
   );

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb: done, errors");
         $finish;
      end
   end

   // output back-pressure, with long hold-offs on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         rsp_tready   <= 1'b0;
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // one input transaction, with random idle cycles ahead of it unless calm
   task automatic send_byte(input logic [7:0] code);
      if (!calm) begin
         while ($urandom_range(0, 99) < IDLE_PERCENT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= code;
      do
         @(posedge clock);
      while (!req_tready);
      codes_sent++;
   endtask

   // mostly ordinary keys, now and then one with the top bit set
   function automatic logic [7:0] random_key();
      logic [7:0] k;
      k = 8'($urandom_range(0, 127));
      if ($urandom_range(0, 9) == 0)
         k[7] = 1'b1;
      return k;
   endfunction

   initial begin
      int         kind;
      int         taps;
      logic [7:0] k;
      logic [7:0] shift_code;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_codes[i])
         send_byte(directed_codes[i]);

      // long output stall while key presses keep coming
      hold_requests <= hold_requests + 1;
      for (int i = 0; i < 40; i++)
         send_byte(i[0] ? KEY_B : KEY_A);

      // random typing sessions, with noise and broken sequences
      while (codes_sent < ITEM_TARGET) begin
         calm <= (codes_sent >= 700 && codes_sent < 1000);
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            k = random_key();
            send_byte(k);
            send_byte(CODE_RELEASE);
            send_byte(k);
         end else if (kind < 60) begin
            shift_code = $urandom_range(0, 1) ? CODE_SHIFT_LEFT : CODE_SHIFT_RIGHT;
            send_byte(shift_code);
            taps = $urandom_range(1, 4);
            repeat (taps) begin
               k = random_key();
               send_byte(k);
               send_byte(CODE_RELEASE);
               send_byte(k);
            end
            send_byte(CODE_RELEASE);
            send_byte(shift_code);
         end else if (kind < 68) begin
            send_byte(CODE_CAPS_LOCK);
            send_byte(CODE_RELEASE);
            send_byte(CODE_CAPS_LOCK);
         end else if (kind < 76) begin
            k = random_key();
            send_byte(CODE_EXTENDED);
            send_byte(k);
            send_byte(CODE_EXTENDED);
            send_byte(CODE_RELEASE);
            send_byte(k);
         end else if (kind < 90) begin
            send_byte(8'($urandom_range(0, 255)));
         end else begin
            taps = $urandom_range(1, 3);
            repeat (taps) send_byte(CODE_RELEASE);
            if ($urandom_range(0, 1))
               send_byte(8'($urandom_range(0, 255)));
         end
      end

      // drain
      req_tvalid <= 1'b0;
      calm       <= 1'b1;
      @(posedge clock);
      while (chars_pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("scan codes sent %0d, characters checked %0d, mismatches %0d",
               codes_sent, chars_checked, mismatch_count);
      $display("covered shift, caps lock, release prefixes, extended codes and a long stall");
      if (mismatch_count == 0 && chars_pending == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
